/* sv/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int PRIO_BITS_DEF = 8;
    localparam int DATA_BITS_DEF = 8;
    localparam int CAP_RESET     = 64;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PLACE = 5'b00100,
        S_DEQ   = 5'b01000,
        S_DONE  = 5'b10000
    } seq_state_t;

    // result handshake and status from the sequencer
    typedef struct packed {
        logic    valid;
        status_t status;
    } res_ctl_t;

endpackage

/* sv/spq_ram.sv */
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/spq_seq.sv */
`timescale 1ns / 1ps

module spq_seq #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    parameter int DATA_BITS = spq_pkg::DATA_BITS_DEF,
    parameter int IDX_W     = $clog2(DEPTH),
    parameter int CNT_W     = $clog2(DEPTH + 1),
    parameter int WORD_W    = PRIO_BITS + DATA_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_clr,
    input  logic [CNT_W-1:0]      cap,
    input  logic                  item_go,
    input  logic                  item_mode,
    input  logic [PRIO_BITS-1:0]  item_prio,
    input  logic [DATA_BITS-1:0]  item_payload,
    output logic                  busy,
    output spq_pkg::res_ctl_t     res_ctl,
    output logic [PRIO_BITS-1:0]  res_prio,
    output logic [DATA_BITS-1:0]  res_payload,
    output logic [CNT_W-1:0]      res_count,
    input  logic                  res_take,
    output logic                  mem_we,
    output logic [IDX_W-1:0]      mem_waddr,
    output logic [WORD_W-1:0]     mem_wdata,
    output logic [IDX_W-1:0]      mem_raddr,
    input  logic [WORD_W-1:0]     mem_rdata
);

    spq_pkg::seq_state_t state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PRIO_BITS-1:0] new_prio_reg, new_prio_next;
    logic [DATA_BITS-1:0] new_data_reg, new_data_next;
    logic [PRIO_BITS-1:0] res_prio_reg, res_prio_next;
    logic [DATA_BITS-1:0] res_data_reg, res_data_next;
    spq_pkg::status_t     res_status_reg, res_status_next;

    logic [IDX_W-1:0]     last_slot;
    logic [IDX_W-1:0]     pv;
    logic [IDX_W-1:0]     ppv;
    logic [IDX_W-1:0]     tail_inc;
    logic [IDX_W-1:0]     head_inc;
    logic [PRIO_BITS-1:0] rd_prio;
    logic                 move_up;

    assign last_slot = IDX_W'(cap - 1'b1);
    assign pv        = (pos_reg == '0) ? last_slot : pos_reg - 1'b1;
    assign ppv       = (pv == '0) ? last_slot : pv - 1'b1;
    assign tail_inc  = (tail_reg == last_slot) ? '0 : tail_reg + 1'b1;
    assign head_inc  = (head_reg == last_slot) ? '0 : head_reg + 1'b1;
    assign rd_prio   = mem_rdata[WORD_W-1 -: PRIO_BITS];
    // shared compare: the new word passes its predecessor only on strictly smaller
    assign move_up   = new_prio_reg < rd_prio;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        new_prio_next   = new_prio_reg;
        new_data_next   = new_data_reg;
        res_prio_next   = res_prio_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = {new_prio_reg, new_data_reg};
        mem_raddr       = (item_mode == spq_pkg::MODE_DEQ) ? head_reg : tail_reg;

        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (item_go)
                begin
                    new_prio_next   = item_prio;
                    new_data_next   = item_payload;
                    res_prio_next   = '0;
                    res_data_next   = '0;
                    res_status_next = spq_pkg::ST_OK;
                    if (item_mode == spq_pkg::MODE_DEQ)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = spq_pkg::ST_EMPTY;
                            state_next      = spq_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = spq_pkg::S_DEQ;
                        end
                    end
                    else if (count_reg >= cap)
                    begin
                        res_status_next = spq_pkg::ST_FULL;
                        state_next      = spq_pkg::S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = {item_prio, item_payload};
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = CNT_W'(1);
                        state_next = spq_pkg::S_DONE;
                    end
                    else
                    begin
                        // read of the old tail is already under way
                        tail_next  = tail_inc;
                        pos_next   = tail_inc;
                        count_next = CNT_W'(count_reg + 1'b1);
                        state_next = spq_pkg::S_SHIFT;
                    end
                end
            end
            spq_pkg::S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_raddr = ppv;
                if (move_up)
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = pv;
                    if (pv == head_reg)
                    begin
                        state_next = spq_pkg::S_PLACE;
                    end
                end
                else
                begin
                    state_next = spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_PLACE:
            begin
                mem_we     = 1'b1;
                state_next = spq_pkg::S_DONE;
            end
            spq_pkg::S_DEQ:
            begin
                res_prio_next = rd_prio;
                res_data_next = mem_rdata[DATA_BITS-1:0];
                count_next    = CNT_W'(count_reg - 1'b1);
                if (count_reg == CNT_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else
                begin
                    head_next = head_inc;
                end
                state_next = spq_pkg::S_DONE;
            end
            spq_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase

        // capacity write empties the queue
        if (cfg_clr)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        new_prio_reg   <= new_prio_next;
        new_data_reg   <= new_data_next;
        res_prio_reg   <= res_prio_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
    end

    assign busy           = (state_reg != spq_pkg::S_IDLE);
    assign res_ctl.valid  = (state_reg == spq_pkg::S_DONE);
    assign res_ctl.status = res_status_reg;
    assign res_prio       = res_prio_reg;
    assign res_payload    = res_data_reg;
    assign res_count      = count_reg;

    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap)
        else $error("entry count above capacity");

    a_shift_not_head: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spq_pkg::S_SHIFT |-> pos_reg != head_reg)
        else $error("insertion walked onto the head slot");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::S_DONE && res_status_reg == spq_pkg::ST_FULL)
        |-> count_reg == cap)
        else $error("full status without a full queue");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == spq_pkg::S_IDLE || state_reg == spq_pkg::S_SHIFT
                    || state_reg == spq_pkg::S_PLACE))
        else $error("slot write outside insertion");

endmodule

/* sv/sorted_insert_priority_queue_unit.sv */
`timescale 1ns / 1ps

// Priority queue kept sorted in a circular slot RAM of DEPTH words. Each input
// word (mode 0 enqueue, mode 1 dequeue) gives one result word with status and
// entry count. Enqueue writes after the tail and walks toward the head, moving
// each larger entry back one slot through a single compare and RAM port, one
// slot a cycle, and passes at most count - 1 entries (up to 63 at DEPTH 64)
// before it writes the new word into its place. Dequeue reads the head slot
// and then registers it; rejected full or empty words and an enqueue into an
// empty queue go straight to the result. The unit handles one word at a time
// and stalls its input meanwhile; a finished result waits in the output
// register while the next word is accepted.
// Writing capacity (0 acts as 1, above DEPTH as DEPTH) empties the queue.
// The slot RAM is not cleared after reset; only data read from live slots is used.
module sorted_insert_priority_queue_unit #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    parameter int DATA_BITS = spq_pkg::DATA_BITS_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 mode,
    input  logic [PRIO_BITS-1:0] item_prio,
    input  logic [DATA_BITS-1:0] item_payload,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [PRIO_BITS-1:0] out_prio,
    output logic [DATA_BITS-1:0] out_payload,
    output logic [1:0]           status,
    output logic [CNT_W-1:0]     count
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int WORD_W  = PRIO_BITS + DATA_BITS;
    localparam int CAP_RST = (spq_pkg::CAP_RESET > DEPTH) ? DEPTH : spq_pkg::CAP_RESET;

    logic [CNT_W-1:0]     cap_reg, cap_next;
    logic                 result_valid_reg;
    logic [PRIO_BITS-1:0] out_prio_reg;
    logic [DATA_BITS-1:0] out_payload_reg;
    spq_pkg::status_t     status_reg;
    logic [CNT_W-1:0]     count_reg;

    logic                 busy;
    logic                 item_go;
    logic                 res_take;
    spq_pkg::res_ctl_t    res_ctl;
    logic [PRIO_BITS-1:0] res_prio;
    logic [DATA_BITS-1:0] res_payload;
    logic [CNT_W-1:0]     res_count;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [WORD_W-1:0]    mem_rdata;

    assign item_stall = busy;
    assign item_go    = item_valid && !busy;
    assign res_take   = res_ctl.valid && (!result_valid_reg || !result_stall);

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cap_next = CNT_W'(1);
        end
        else if (cfg_wr_data > CNT_W'(DEPTH))
        begin
            cap_next = CNT_W'(DEPTH);
        end
        else
        begin
            cap_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg          <= CNT_W'(CAP_RST);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cap_next;
            end
            if (res_take)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_prio_reg    <= res_prio;
            out_payload_reg <= res_payload;
            status_reg      <= res_ctl.status;
            count_reg       <= res_count;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_prio     = out_prio_reg;
    assign out_payload  = out_payload_reg;
    assign status       = status_reg;
    assign count        = count_reg;

    spq_seq #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .DATA_BITS (DATA_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .WORD_W    (WORD_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_clr      (cfg_wr_en),
        .cap          (cap_reg),
        .item_go      (item_go),
        .item_mode    (mode),
        .item_prio    (item_prio),
        .item_payload (item_payload),
        .busy         (busy),
        .res_ctl      (res_ctl),
        .res_prio     (res_prio),
        .res_payload  (res_payload),
        .res_count    (res_count),
        .res_take     (res_take),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    spq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
